FILE: rtl/lcps_pkg.sv
// Shared constants, types and state encodings of the line clip and point sampler.
package lcps_pkg;

  localparam int CW = 32;                 // coordinate width, signed Q16.16
  localparam int DW = CW + 1;             // difference and magnitude width
  localparam int PW = 2 * DW;             // product width
  localparam int QW = 36;                 // saturating quotient width
  localparam logic [QW-1:0] QSAT = QW'(64'd1 << 35);

  localparam int MAX_POINTS = 64;
  localparam int CNT_W = 7;               // point_count register width
  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_POINTS);

  localparam int STEP_W = 7;
  localparam logic [STEP_W-1:0] MUL_STEPS = STEP_W'(DW);
  localparam logic [STEP_W-1:0] DIV_STEPS = STEP_W'(PW);

  localparam int QDEPTH = 2;
  localparam int QA_W = 1;
  localparam int QC_W = 2;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_X_MIN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_X_MAX = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_Y_MIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_Y_MAX = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT = 3'd4;

  typedef struct packed {
    logic signed [CW-1:0] sx;
    logic signed [CW-1:0] sy;
    logic signed [CW-1:0] ex;
    logic signed [CW-1:0] ey;
    logic                 is_line;
  } job_t;

  typedef struct packed {
    logic signed [CW-1:0] x_min;
    logic signed [CW-1:0] x_max;
    logic signed [CW-1:0] y_min;
    logic signed [CW-1:0] y_max;
    logic [CNT_W-1:0]     count;
  } view_cfg_t;

  typedef struct packed {
    logic          start;
    logic [DW-1:0] a;
    logic [DW-1:0] b;
    logic [DW-1:0] d;
  } md_req_t;

  typedef struct packed {
    logic          done;
    logic [QW-1:0] q;
    logic [DW-1:0] r;
    logic [QW-1:0] mag;
  } md_rsp_t;

  typedef enum logic [1:0] {MD_IDLE, MD_MUL, MD_DIV} md_state_t;

  typedef enum logic [3:0] {
    BK_IDLE, BK_CLIP_ISSUE, BK_CLIP_WAIT, BK_INTERP,
    BK_DIVX, BK_DIVX_WAIT, BK_DIVY, BK_DIVY_WAIT, BK_EMIT
  } back_state_t;

endpackage

FILE: rtl/lcps_if.sv
// Channel interfaces: input items, result points and configuration writes.
interface lcps_in_if;
  import lcps_pkg::*;
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] start_x;
  logic signed [CW-1:0] start_y;
  logic signed [CW-1:0] end_x;
  logic signed [CW-1:0] end_y;
  logic                 is_line;
  modport source (output valid, start_x, start_y, end_x, end_y, is_line, input ready);
  modport sink (input valid, start_x, start_y, end_x, end_y, is_line, output ready);
endinterface

interface lcps_out_if;
  import lcps_pkg::*;
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] point_x;
  logic signed [CW-1:0] point_y;
  logic                 last_point;
  modport source (output valid, point_x, point_y, last_point, input ready);
  modport sink (input valid, point_x, point_y, last_point, output ready);
endinterface

interface lcps_cfg_if;
  import lcps_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CW-1:0]        data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/lcps_front.sv
// Front end: accepts items, drops degenerate lines and queues jobs for the back end.
module lcps_front (
  input  logic          clk,
  input  logic          rst_n,
  lcps_in_if.sink       in_ch,
  output lcps_pkg::job_t job,
  output logic          job_valid,
  input  logic          job_ready
);
  import lcps_pkg::*;

  job_t            mem_r [QDEPTH];
  logic [QA_W-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [QC_W-1:0] cnt_r, cnt_nxt;
  logic            keep, push, pop;
  job_t            in_job;

  assign in_job.sx      = in_ch.start_x;
  assign in_job.sy      = in_ch.start_y;
  assign in_job.ex      = in_ch.end_x;
  assign in_job.ey      = in_ch.end_y;
  assign in_job.is_line = in_ch.is_line;

  // A line through two equal points has no direction and yields nothing.
  assign keep = !(in_ch.is_line && in_ch.start_x == in_ch.end_x &&
                  in_ch.start_y == in_ch.end_y);
  assign in_ch.ready = (cnt_r != QC_W'(QDEPTH));
  assign push = in_ch.valid && in_ch.ready && keep;
  assign job_valid = (cnt_r != '0);
  assign job = mem_r[rp_r];
  assign pop = job_valid && job_ready;

  always_comb begin
    wp_nxt = push ? wp_r + 1'b1 : wp_r;
    rp_nxt = pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + QC_W'(push) - QC_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) begin
      mem_r[wp_r] <= in_job;
    end
  end

endmodule

FILE: rtl/lcps_muldiv.sv
// Shared sequential unit: round(a*b/d) by shift-add multiply and restoring divide.
module lcps_muldiv (
  input  logic              clk,
  input  logic              rst_n,
  input  lcps_pkg::md_req_t req,
  output lcps_pkg::md_rsp_t rsp
);
  import lcps_pkg::*;

  md_state_t         state_r, state_nxt;
  logic [PW-1:0]     mcand_r, mcand_nxt, prod_r, prod_nxt;
  logic [DW-1:0]     mplier_r, mplier_nxt, d_r, d_nxt, rem_r, rem_nxt;
  logic [QW-1:0]     q_r, q_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic              done_r, done_nxt;
  logic [DW:0]       sh, diffv;
  logic              ge;
  logic [QW:0]       qn;

  always_comb begin
    sh    = {rem_r, prod_r[PW-1]};
    ge    = sh >= {1'b0, d_r};
    diffv = sh - {1'b0, d_r};
    qn    = {q_r, ge};

    state_nxt  = state_r;
    mcand_nxt  = mcand_r;
    prod_nxt   = prod_r;
    mplier_nxt = mplier_r;
    d_nxt      = d_r;
    rem_nxt    = rem_r;
    q_nxt      = q_r;
    cnt_nxt    = cnt_r;
    done_nxt   = 1'b0;

    case (state_r)
      MD_IDLE: begin
        if (req.start) begin
          mcand_nxt  = {{(PW-DW){1'b0}}, req.a};
          mplier_nxt = req.b;
          prod_nxt   = '0;
          d_nxt      = req.d;
          rem_nxt    = '0;
          q_nxt      = '0;
          cnt_nxt    = MUL_STEPS;
          state_nxt  = MD_MUL;
        end
      end
      MD_MUL: begin
        if (mplier_r[0]) begin
          prod_nxt = prod_r + mcand_r;
        end
        mcand_nxt  = {mcand_r[PW-2:0], 1'b0};
        mplier_nxt = {1'b0, mplier_r[DW-1:1]};
        cnt_nxt    = cnt_r - 1'b1;
        if (cnt_r == STEP_W'(1)) begin
          cnt_nxt   = DIV_STEPS;
          state_nxt = MD_DIV;
        end
      end
      MD_DIV: begin
        rem_nxt  = ge ? diffv[DW-1:0] : sh[DW-1:0];
        prod_nxt = {prod_r[PW-2:0], 1'b0};
        // Once the quotient passes the limit it stays pinned there.
        q_nxt    = (qn > {1'b0, QSAT}) ? QSAT : qn[QW-1:0];
        cnt_nxt  = cnt_r - 1'b1;
        if (cnt_r == STEP_W'(1)) begin
          done_nxt  = 1'b1;
          state_nxt = MD_IDLE;
        end
      end
      default: state_nxt = MD_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= MD_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
    mcand_r  <= mcand_nxt;
    prod_r   <= prod_nxt;
    mplier_r <= mplier_nxt;
    d_r      <= d_nxt;
    rem_r    <= rem_nxt;
    q_r      <= q_nxt;
    cnt_r    <= cnt_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.q    = q_r;
  assign rsp.r    = rem_r;
  assign rsp.mag  = (q_r < QSAT && {rem_r, 1'b0} >= {1'b0, d_r}) ? q_r + 1'b1 : q_r;

endmodule

FILE: rtl/lcps_back.sv
// Back end: clips lines to the viewport, sets up interpolation and emits points.
module lcps_back (
  input  logic                clk,
  input  logic                rst_n,
  input  lcps_pkg::job_t      job,
  input  logic                job_valid,
  output logic                job_ready,
  input  lcps_pkg::view_cfg_t cfg,
  output lcps_pkg::md_req_t   md_req,
  input  lcps_pkg::md_rsp_t   md_rsp,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [lcps_pkg::CW-1:0] point_x,
  output logic [lcps_pkg::CW-1:0] point_y,
  output logic                last_point
);
  import lcps_pkg::*;

  function automatic logic [DW-1:0] mag33(input logic [DW-1:0] v);
    return v[DW-1] ? (~v + 1'b1) : v;
  endfunction

  back_state_t      state_r, state_nxt;
  job_t             job_r, job_nxt;
  logic [1:0]       op_r, op_nxt;
  logic [1:0]       hits_r, hits_nxt;
  logic             neg_r, neg_nxt;
  logic [CW-1:0]    ax_r, ax_nxt, ay_r, ay_nxt, bx_r, bx_nxt, by_r, by_nxt;
  logic [CNT_W-1:0] n_r, n_nxt;
  logic [IDX_W-1:0] m_r, m_nxt, idx_r, idx_nxt;
  logic [DW-1:0]    qsx_r, qsx_nxt, qsy_r, qsy_nxt, qax_r, qax_nxt, qay_r, qay_nxt;
  logic [IDX_W-1:0] rsx_r, rsx_nxt, rsy_r, rsy_nxt, rax_r, rax_nxt, ray_r, ray_nxt;
  logic             negx_r, negx_nxt, negy_r, negy_nxt;
  logic [CW-1:0]    px_r, px_nxt, py_r, py_nxt;
  logic             last_r, last_nxt, oval_r, oval_nxt;

  // Clip operation set-up, derived from the current edge, and point interpolation terms.
  logic             vert;
  logic [CW-1:0]    ev, base, lo, hi, s_perp;
  logic [DW-1:0]    dx, dy, num, den, off;
  logic             op_ok;
  logic [DW+3:0]    val;
  logic             in_rng;
  logic [DW-1:0]    diff_x, diff_y;
  logic [CNT_W-1:0] n_sat;
  logic             rnd_x, rnd_y, ld;
  logic [DW:0]      sum_x, sum_y;
  logic [DW+1:0]    ptx, pty;
  logic [IDX_W:0]   rsum_x, rsum_y;

  always_comb begin
    dx   = {job_r.ex[CW-1], job_r.ex} - {job_r.sx[CW-1], job_r.sx};
    dy   = {job_r.ey[CW-1], job_r.ey} - {job_r.sy[CW-1], job_r.sy};
    vert = !op_r[1];
    case (op_r)
      2'd0:    ev = cfg.x_min;
      2'd1:    ev = cfg.x_max;
      2'd2:    ev = cfg.y_min;
      default: ev = cfg.y_max;
    endcase
    s_perp = vert ? job_r.sx : job_r.sy;
    off    = {ev[CW-1], ev} - {s_perp[CW-1], s_perp};
    num    = vert ? dy : dx;
    den    = vert ? dx : dy;
    base   = vert ? job_r.sy : job_r.sx;
    lo     = vert ? cfg.y_min : cfg.x_min;
    hi     = vert ? cfg.y_max : cfg.x_max;
    op_ok  = (den != '0);
    val    = {{5{base[CW-1]}}, base} +
             (neg_r ? -{1'b0, md_rsp.mag} : {1'b0, md_rsp.mag});
    in_rng = $signed(val) >= $signed({{5{lo[CW-1]}}, lo}) &&
             $signed(val) <= $signed({{5{hi[CW-1]}}, hi});

    diff_x = {bx_r[CW-1], bx_r} - {ax_r[CW-1], ax_r};
    diff_y = {by_r[CW-1], by_r} - {ay_r[CW-1], ay_r};
    if (cfg.count == '0) begin
      n_sat = CNT_W'(1);
    end else if (cfg.count > MAX_CNT) begin
      n_sat = MAX_CNT;
    end else begin
      n_sat = cfg.count;
    end

    rnd_x  = (n_r != CNT_W'(1)) && ({rax_r, 1'b0} >= {1'b0, m_r});
    rnd_y  = (n_r != CNT_W'(1)) && ({ray_r, 1'b0} >= {1'b0, m_r});
    sum_x  = {1'b0, qax_r} + (DW+1)'(rnd_x);
    sum_y  = {1'b0, qay_r} + (DW+1)'(rnd_y);
    ptx    = {{3{ax_r[CW-1]}}, ax_r} + (negx_r ? -{1'b0, sum_x} : {1'b0, sum_x});
    pty    = {{3{ay_r[CW-1]}}, ay_r} + (negy_r ? -{1'b0, sum_y} : {1'b0, sum_y});
    rsum_x = {1'b0, rax_r} + {1'b0, rsx_r};
    rsum_y = {1'b0, ray_r} + {1'b0, rsy_r};
  end

  always_comb begin
    state_nxt = state_r;
    job_nxt   = job_r;
    op_nxt    = op_r;
    hits_nxt  = hits_r;
    neg_nxt   = neg_r;
    ax_nxt = ax_r; ay_nxt = ay_r; bx_nxt = bx_r; by_nxt = by_r;
    n_nxt = n_r; m_nxt = m_r; idx_nxt = idx_r;
    qsx_nxt = qsx_r; qsy_nxt = qsy_r; rsx_nxt = rsx_r; rsy_nxt = rsy_r;
    qax_nxt = qax_r; qay_nxt = qay_r; rax_nxt = rax_r; ray_nxt = ray_r;
    negx_nxt = negx_r; negy_nxt = negy_r;
    px_nxt = px_r; py_nxt = py_r; last_nxt = last_r;
    oval_nxt = oval_r && !out_ready;
    job_ready = 1'b0;
    md_req.start = 1'b0;
    md_req.a = mag33(num);
    md_req.b = mag33(off);
    md_req.d = mag33(den);
    ld = !oval_r || out_ready;

    case (state_r)
      BK_IDLE: begin
        job_ready = 1'b1;
        if (job_valid) begin
          job_nxt = job;
          ax_nxt = job.sx; ay_nxt = job.sy; bx_nxt = job.ex; by_nxt = job.ey;
          op_nxt = '0;
          hits_nxt = '0;
          state_nxt = job.is_line ? BK_CLIP_ISSUE : BK_INTERP;
        end
      end
      BK_CLIP_ISSUE: begin
        if (op_ok) begin
          md_req.start = 1'b1;
          neg_nxt = num[DW-1] ^ off[DW-1] ^ den[DW-1];
          state_nxt = BK_CLIP_WAIT;
        end else if (op_r == 2'd3) begin
          state_nxt = BK_IDLE;
        end else begin
          op_nxt = op_r + 1'b1;
        end
      end
      BK_CLIP_WAIT: begin
        if (md_rsp.done) begin
          if (in_rng) begin
            hits_nxt = hits_r + 1'b1;
            if (hits_r == 2'd0) begin
              ax_nxt = vert ? ev : val[CW-1:0];
              ay_nxt = vert ? val[CW-1:0] : ev;
            end else begin
              bx_nxt = vert ? ev : val[CW-1:0];
              by_nxt = vert ? val[CW-1:0] : ev;
            end
          end
          // The first two crossings win; later edges are not looked at.
          if (in_rng && hits_r == 2'd1) begin
            state_nxt = BK_INTERP;
          end else if (op_r == 2'd3) begin
            state_nxt = BK_IDLE;
          end else begin
            op_nxt = op_r + 1'b1;
            state_nxt = BK_CLIP_ISSUE;
          end
        end
      end
      BK_INTERP: begin
        n_nxt = n_sat;
        m_nxt = IDX_W'(n_sat - 1'b1);
        idx_nxt = '0;
        qax_nxt = '0; rax_nxt = '0; qay_nxt = '0; ray_nxt = '0;
        qsx_nxt = '0; rsx_nxt = '0; qsy_nxt = '0; rsy_nxt = '0;
        negx_nxt = 1'b0; negy_nxt = 1'b0;
        state_nxt = (n_sat == CNT_W'(1)) ? BK_EMIT : BK_DIVX;
      end
      BK_DIVX: begin
        md_req.start = 1'b1;
        md_req.a = mag33(diff_x);
        md_req.b = DW'(1);
        md_req.d = DW'(m_r);
        negx_nxt = diff_x[DW-1];
        state_nxt = BK_DIVX_WAIT;
      end
      BK_DIVX_WAIT: begin
        if (md_rsp.done) begin
          qsx_nxt = md_rsp.q[DW-1:0];
          rsx_nxt = md_rsp.r[IDX_W-1:0];
          state_nxt = BK_DIVY;
        end
      end
      BK_DIVY: begin
        md_req.start = 1'b1;
        md_req.a = mag33(diff_y);
        md_req.b = DW'(1);
        md_req.d = DW'(m_r);
        negy_nxt = diff_y[DW-1];
        state_nxt = BK_DIVY_WAIT;
      end
      BK_DIVY_WAIT: begin
        if (md_rsp.done) begin
          qsy_nxt = md_rsp.q[DW-1:0];
          rsy_nxt = md_rsp.r[IDX_W-1:0];
          state_nxt = BK_EMIT;
        end
      end
      BK_EMIT: begin
        if (ld) begin
          px_nxt = ptx[CW-1:0];
          py_nxt = pty[CW-1:0];
          last_nxt = (CNT_W'(idx_r) == n_r - 1'b1);
          oval_nxt = 1'b1;
          idx_nxt = idx_r + 1'b1;
          // Step the running quotient and remainder of i*|D|/m.
          if (rsum_x >= {1'b0, m_r}) begin
            rax_nxt = IDX_W'(rsum_x - {1'b0, m_r});
            qax_nxt = qax_r + qsx_r + 1'b1;
          end else begin
            rax_nxt = rsum_x[IDX_W-1:0];
            qax_nxt = qax_r + qsx_r;
          end
          if (rsum_y >= {1'b0, m_r}) begin
            ray_nxt = IDX_W'(rsum_y - {1'b0, m_r});
            qay_nxt = qay_r + qsy_r + 1'b1;
          end else begin
            ray_nxt = rsum_y[IDX_W-1:0];
            qay_nxt = qay_r + qsy_r;
          end
          if (CNT_W'(idx_r) == n_r - 1'b1) begin
            state_nxt = BK_IDLE;
          end
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      oval_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      oval_r  <= oval_nxt;
    end
    job_r <= job_nxt; op_r <= op_nxt; hits_r <= hits_nxt; neg_r <= neg_nxt;
    ax_r <= ax_nxt; ay_r <= ay_nxt; bx_r <= bx_nxt; by_r <= by_nxt;
    n_r <= n_nxt; m_r <= m_nxt; idx_r <= idx_nxt;
    qsx_r <= qsx_nxt; qsy_r <= qsy_nxt; rsx_r <= rsx_nxt; rsy_r <= rsy_nxt;
    qax_r <= qax_nxt; qay_r <= qay_nxt; rax_r <= rax_nxt; ray_r <= ray_nxt;
    negx_r <= negx_nxt; negy_r <= negy_nxt;
    px_r <= px_nxt; py_r <= py_nxt; last_r <= last_nxt;
  end

  assign out_valid  = oval_r;
  assign point_x    = px_r;
  assign point_y    = py_r;
  assign last_point = last_r;

endmodule

FILE: rtl/line_clip_and_point_sampler.sv
// Each multiply-divide runs 33 multiply and 66 divide steps in one shared unit.
// A segment item needs up to two of them, a line item up to six, then one point per cycle
// while the receiver is ready; the back end works on one item at a time.
// A two-entry job queue lets new items arrive while the back end works.
// Synchronous active-low reset empties the queue, idles the sequencers and restores the
// viewport to +/-10.0 with 64 points per item.
module line_clip_and_point_sampler (
  input  logic       clk,
  input  logic       rst_n,
  lcps_in_if.sink    in_ch,
  lcps_out_if.source out_ch,
  lcps_cfg_if.sink   cfg_ch
);
  import lcps_pkg::*;

  view_cfg_t cfg_r, cfg_nxt;
  job_t      job;
  logic      job_valid, job_ready;
  md_req_t   md_req;
  md_rsp_t   md_rsp;

  assign cfg_ch.ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_X_MIN: cfg_nxt.x_min = cfg_ch.data;
        REG_X_MAX: cfg_nxt.x_max = cfg_ch.data;
        REG_Y_MIN: cfg_nxt.y_min = cfg_ch.data;
        REG_Y_MAX: cfg_nxt.y_max = cfg_ch.data;
        REG_COUNT: cfg_nxt.count = cfg_ch.data[CNT_W-1:0];
        default:   cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.x_min <= -CW'(655360);
      cfg_r.x_max <= CW'(655360);
      cfg_r.y_min <= -CW'(655360);
      cfg_r.y_max <= CW'(655360);
      cfg_r.count <= MAX_CNT;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  lcps_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .job       (job),
    .job_valid (job_valid),
    .job_ready (job_ready)
  );

  lcps_muldiv u_muldiv (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (md_req),
    .rsp   (md_rsp)
  );

  lcps_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .job        (job),
    .job_valid  (job_valid),
    .job_ready  (job_ready),
    .cfg        (cfg_r),
    .md_req     (md_req),
    .md_rsp     (md_rsp),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .point_x    (out_ch.point_x),
    .point_y    (out_ch.point_y),
    .last_point (out_ch.last_point)
  );

endmodule

FILE: rtl/lcps_checker.sv
// Port-level checker of the line clip and point sampler, bound to the top level.
module lcps_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] point_x,
  input logic [31:0] point_y,
  input logic        last_point
);

  // A stalled point must hold still.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(point_x) && $stable(point_y) &&
    $stable(last_point))
    else $error("result changed while stalled");

  // Within a run, points follow each other without gaps.
  a_run_dense: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !last_point |=> out_valid)
    else $error("gap inside a run of points");

  a_rst_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_rst_in: assert property (@(posedge clk) !rst_n |=> in_ready)
    else $error("input not ready after reset");

endmodule

bind line_clip_and_point_sampler lcps_checker u_lcps_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .point_x    (out_ch.point_x),
  .point_y    (out_ch.point_y),
  .last_point (out_ch.last_point)
);

FILE: test/tb.sv
// Testbench for line_clip_and_point_sampler: directed and random items checked by a scoreboard.
`timescale 1ns / 1ps

module tb;
  import lcps_pkg::*;

  typedef struct {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic                 last;
  } point_t;

  class point_scoreboard;
    point_t    exp_q[$];
    longint    x_min, x_max, y_min, y_max;
    bit [6:0]  count;
    int        mismatches, points_seen, items_seen, silent_items;

    function new();
      x_min = -655360; x_max = 655360; y_min = -655360; y_max = 655360;
      count = 64;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CW-1:0] val);
      case (idx)
        REG_X_MIN: x_min = longint'(signed'(val));
        REG_X_MAX: x_max = longint'(signed'(val));
        REG_Y_MIN: y_min = longint'(signed'(val));
        REG_Y_MAX: y_max = longint'(signed'(val));
        REG_COUNT: count = val[6:0];
        default: ;
      endcase
    endfunction

    // Rounded a*b/d with ties away from zero, clamped at the quotient limit.
    function longint scaled_quotient(longint a, longint b, longint d);
      logic [127:0] p, q, r;
      p = 128'(a) * 128'(b);
      q = p / 128'(d);
      r = p % 128'(d);
      if (q >= 128'(QSAT)) return longint'(QSAT);
      if (2 * r >= 128'(d)) q = q + 1;
      return longint'(q);
    endfunction

    function longint shifted(longint base, longint num, longint off, longint den);
      bit     neg;
      longint m;
      neg = ((num < 0) != (off < 0)) != (den < 0);
      m = scaled_quotient(num < 0 ? -num : num, off < 0 ? -off : off, den < 0 ? -den : den);
      return neg ? base - m : base + m;
    endfunction

    function void note_item(job_t j);
      longint sx, sy, ex, ey, ax, ay, bx, by, dx, dy, v;
      longint hx[4], hy[4];
      int     hits, n;
      point_t p;
      sx = j.sx; sy = j.sy; ex = j.ex; ey = j.ey;
      ax = sx; ay = sy; bx = ex; by = ey;
      items_seen++;
      if (j.is_line) begin
        dx = ex - sx; dy = ey - sy; hits = 0;
        if (dx == 0 && dy == 0) begin
          silent_items++;
          return;
        end
        if (dx != 0) begin
          v = shifted(sy, dy, x_min - sx, dx);
          if (v >= y_min && v <= y_max) begin hx[hits] = x_min; hy[hits] = v; hits++; end
          v = shifted(sy, dy, x_max - sx, dx);
          if (v >= y_min && v <= y_max) begin hx[hits] = x_max; hy[hits] = v; hits++; end
        end
        if (dy != 0) begin
          v = shifted(sx, dx, y_min - sy, dy);
          if (v >= x_min && v <= x_max) begin hx[hits] = v; hy[hits] = y_min; hits++; end
          v = shifted(sx, dx, y_max - sy, dy);
          if (v >= x_min && v <= x_max) begin hx[hits] = v; hy[hits] = y_max; hits++; end
        end
        if (hits < 2) begin
          silent_items++;
          return;
        end
        ax = hx[0]; ay = hy[0]; bx = hx[1]; by = hy[1];
      end
      n = count;
      if (n < 1) n = 1;
      if (n > MAX_POINTS) n = MAX_POINTS;
      for (int i = 0; i < n; i++) begin
        p.x = ax[CW-1:0]; p.y = ay[CW-1:0];
        if (n > 1) begin
          v = shifted(ax, bx - ax, i, n - 1); p.x = v[CW-1:0];
          v = shifted(ay, by - ay, i, n - 1); p.y = v[CW-1:0];
        end
        p.last = (i + 1 == n);
        exp_q.push_back(p);
      end
    endfunction

    function void check_point(point_t got);
      point_t e;
      points_seen++;
      if (exp_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected point x=%0d y=%0d last=%0b", got.x, got.y, got.last);
        return;
      end
      e = exp_q.pop_front();
      if (got.x !== e.x || got.y !== e.y || got.last !== e.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: point %0d expected x=%0d y=%0d last=%0b, got x=%0d y=%0d last=%0b",
                   points_seen, e.x, e.y, e.last, got.x, got.y, got.last);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  lcps_in_if  in_ch();
  lcps_out_if out_ch();
  lcps_cfg_if cfg_ch();

  line_clip_and_point_sampler dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source), .cfg_ch(cfg_ch.sink)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  point_scoreboard sb = new();
  int  stall_mode = 0;
  bit  gaps_on = 1'b1;
  int  burst_left = 0;

  initial begin
    in_ch.valid = 1'b0; in_ch.start_x = '0; in_ch.start_y = '0;
    in_ch.end_x = '0; in_ch.end_y = '0; in_ch.is_line = 1'b0;
    cfg_ch.valid = 1'b0; cfg_ch.index = REG_X_MIN; cfg_ch.data = '0;
    out_ch.ready = 1'b0;
  end

  // The receiver follows its own stall pattern, chosen per phase.
  always @(negedge clk) begin
    case (stall_mode)
      0: out_ch.ready <= 1'b1;
      1: out_ch.ready <= ($urandom_range(0, 3) != 0);
      default: out_ch.ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  always @(posedge clk) begin
    point_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.x = out_ch.point_x; got.y = out_ch.point_y; got.last = out_ch.last_point;
      sb.check_point(got);
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CW-1:0] val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1; cfg_ch.index <= idx; cfg_ch.data <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Valid stays high across a burst; it drops for the gap between bursts when gaps are on, and when draining.
  task automatic send_item(logic signed [CW-1:0] sx, logic signed [CW-1:0] sy,
                           logic signed [CW-1:0] ex, logic signed [CW-1:0] ey, logic ln);
    job_t j;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 10);
      if (gaps_on) begin
        @(negedge clk);
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end
    end
    if (!gaps_on || in_ch.valid) @(negedge clk);
    else if ($time == 0) @(negedge clk);
    in_ch.valid <= 1'b1;
    in_ch.start_x <= sx; in_ch.start_y <= sy; in_ch.end_x <= ex; in_ch.end_y <= ey;
    in_ch.is_line <= ln;
    do @(posedge clk); while (!in_ch.ready);
    j.sx = sx; j.sy = sy; j.ex = ex; j.ey = ey; j.is_line = ln;
    sb.note_item(j);
    burst_left--;
  endtask

  // Queued items may still be working without producing points, hence the extra wait.
  task automatic drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    burst_left = 0;
    while (sb.exp_q.size() != 0) @(posedge clk);
    repeat (2000) @(posedge clk);
  endtask

  function automatic logic signed [CW-1:0] pick_coord();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 65535) - 32768;
      2: return $urandom_range(0, 3) == 0 ? 32'sh8000_0000 : 32'sh7fff_ffff;
      default: return $urandom_range(0, 1572864) - 786432;
    endcase
  endfunction

  task automatic random_items(int n);
    for (int i = 0; i < n; i++)
      send_item(pick_coord(), pick_coord(), pick_coord(), pick_coord(),
                $urandom_range(0, 2) != 0);
  endtask

  localparam logic signed [CW-1:0] C10 = 655360;
  localparam logic signed [CW-1:0] SMIN = 32'sh8000_0000;
  localparam logic signed [CW-1:0] SMAX = 32'sh7fff_ffff;

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed items under the reset viewport and count.
    send_item(0, 0, 0, 0, 1'b0);
    send_item(SMIN, SMIN, SMAX, SMAX, 1'b0);
    send_item(SMAX, SMIN, SMIN, SMAX, 1'b0);
    send_item(65536, 65536, 65536, 65536, 1'b1);
    send_item(0, 0, 65536, 0, 1'b1);
    send_item(0, 0, 0, -65536, 1'b1);
    send_item(-C10, -C10, C10, C10, 1'b1);
    send_item(0, 0, 65536, 65536, 1'b1);
    send_item(0, 20 * 65536, 65536, 20 * 65536, 1'b1);
    send_item(SMIN, SMAX, SMAX, SMIN, 1'b1);
    send_item(3, -7, 5, 11, 1'b1);
    send_item(C10, 0, 0, C10, 1'b1);
    drain();

    write_reg(REG_COUNT, 1);
    send_item(123456, -98765, 5, 5, 1'b0);
    send_item(0, 0, 65536, 32768, 1'b1);
    drain();

    write_reg(REG_COUNT, 0);
    send_item(-1, 2, 3, -4, 1'b0);
    drain();

    write_reg(REG_X_MIN, SMIN);
    write_reg(REG_X_MAX, SMAX);
    write_reg(REG_Y_MIN, SMIN);
    write_reg(REG_Y_MAX, SMAX);
    write_reg(REG_COUNT, 127);
    send_item(0, 0, 1, 1, 1'b1);
    send_item(SMIN, 0, SMAX, 1, 1'b1);
    send_item(7, 7, 7, SMAX, 1'b1);
    drain();

    write_reg(REG_X_MIN, C10);
    write_reg(REG_X_MAX, -C10);
    write_reg(REG_COUNT, 2);
    send_item(0, 0, 65536, 65536, 1'b1);
    send_item(0, 0, 65536, 65536, 1'b0);
    drain();

    // Random phases, each with its own count and idling; all but the second also change the viewport.
    for (int ph = 0; ph < 6; ph++) begin
      stall_mode = ph % 3;
      gaps_on = (ph != 2);
      case (ph)
        0: begin
          write_reg(REG_X_MIN, -C10); write_reg(REG_X_MAX, C10);
          write_reg(REG_Y_MIN, -C10); write_reg(REG_Y_MAX, C10);
          write_reg(REG_COUNT, 64);
        end
        1: write_reg(REG_COUNT, 1);
        2: begin
          write_reg(REG_X_MIN, SMIN); write_reg(REG_X_MAX, SMAX);
          write_reg(REG_Y_MIN, SMIN); write_reg(REG_Y_MAX, SMAX);
          write_reg(REG_COUNT, 127);
        end
        3: begin
          write_reg(REG_X_MIN, -65536); write_reg(REG_X_MAX, 3 * 65536);
          write_reg(REG_Y_MIN, -2 * 65536); write_reg(REG_Y_MAX, 65536);
          write_reg(REG_COUNT, 0);
        end
        4: begin
          write_reg(REG_Y_MIN, C10); write_reg(REG_Y_MAX, -C10);
          write_reg(REG_COUNT, 2);
        end
        default: begin
          write_reg(REG_X_MIN, -$urandom_range(0, 786432));
          write_reg(REG_X_MAX, $urandom_range(0, 786432));
          write_reg(REG_Y_MIN, -$urandom_range(0, 786432));
          write_reg(REG_Y_MAX, $urandom_range(0, 786432));
          write_reg(REG_COUNT, $urandom_range(1, 64));
        end
      endcase
      random_items(78);
      drain();
    end

    $display("Covered %0d items (%0d gave no points) and %0d points over several viewports",
             sb.items_seen, sb.silent_items, sb.points_seen);
    $display("and point counts, with sender gaps and receiver stalls.");
    if (sb.mismatches == 0 && sb.exp_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatches, %0d points missing", sb.mismatches, sb.exp_q.size());
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("Timeout with %0d points outstanding", sb.exp_q.size());
    $display("FAILED: results differ");
    $finish;
  end

endmodule

FILE: sim.f
rtl/lcps_pkg.sv
rtl/lcps_if.sv
rtl/lcps_front.sv
rtl/lcps_muldiv.sv
rtl/lcps_back.sv
rtl/line_clip_and_point_sampler.sv
rtl/lcps_checker.sv
test/tb.sv
